FILE: rtl/edmc_pkg.sv
// Types, constants and lookup functions shared by the event-driven mode controller.
package edmc_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 10;
    localparam int NUM_MODES           = 13;
    localparam int STAT_W              = 32;
    localparam int CFG_DATA_W          = 1;

    typedef enum logic [3:0] {
        MODE_INIT        = 4'd0,
        MODE_IDLE        = 4'd1,
        MODE_MANUAL      = 4'd2,
        MODE_CALIBRATION = 4'd3,
        MODE_READY       = 4'd4,
        MODE_HEATING     = 4'd5,
        MODE_EXECUTING   = 4'd6,
        MODE_PAUSED      = 4'd7,
        MODE_NORMAL_EXIT = 4'd8,
        MODE_CAL_ERROR   = 4'd9,
        MODE_HEAT_ERROR  = 4'd10,
        MODE_DATA_ERROR  = 4'd11,
        MODE_LOCK        = 4'd12
    } mode_t;

    typedef enum logic [1:0] {
        CMD_POST    = 2'd0,
        CMD_PROCESS = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_QUEUE_FULL    = 3'd1,
        ST_BAD_EVENT     = 3'd2,
        ST_NO_TRANSITION = 3'd3,
        ST_NOTHING       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        COLOR_YELLOW = 2'd0,
        COLOR_RED    = 2'd1,
        COLOR_ASH    = 2'd2,
        COLOR_OTHER  = 2'd3
    } color_t;

    typedef enum logic [0:0] {
        CFG_RUN_ENABLE   = 1'b0,
        CFG_STATS_ENABLE = 1'b1
    } cfg_reg_t;

    localparam logic [4:0] EV_INIT_DONE           = 5'd0;
    localparam logic [4:0] EV_SELECT_MANUAL       = 5'd1;
    localparam logic [4:0] EV_EXIT_MANUAL         = 5'd2;
    localparam logic [4:0] EV_TASK_SENT           = 5'd3;
    localparam logic [4:0] EV_REQUEST_CALIBRATION = 5'd4;
    localparam logic [4:0] EV_CALIBRATION_SUCCESS = 5'd5;
    localparam logic [4:0] EV_CALIBRATION_ERROR   = 5'd6;
    localparam logic [4:0] EV_CANCEL_TASK         = 5'd7;
    localparam logic [4:0] EV_CALIBRATION_DONE    = 5'd8;
    localparam logic [4:0] EV_TASK_APPROVED       = 5'd9;
    localparam logic [4:0] EV_HEATING_SUCCESS     = 5'd10;
    localparam logic [4:0] EV_HEATING_ERROR       = 5'd11;
    localparam logic [4:0] EV_PAUSE_REQUEST       = 5'd12;
    localparam logic [4:0] EV_TASK_DONE           = 5'd13;
    localparam logic [4:0] EV_DATA_ERROR          = 5'd14;
    localparam logic [4:0] EV_EXIT_REQUEST        = 5'd15;
    localparam logic [4:0] EV_CONTINUE_TASK       = 5'd16;
    localparam logic [4:0] EV_COOLDOWN_COMPLETE   = 5'd17;
    localparam logic [4:0] EV_COOLING_ERROR       = 5'd18;
    localparam logic [4:0] NUM_EVENTS             = 5'd19;

    typedef struct packed {
        cmd_t       cmd;
        logic [4:0] event_code;
        logic [3:0] stat_select;
    } in_item_t;

    typedef struct packed {
        mode_t              mode_now;
        mode_t              mode_before;
        status_t            status;
        logic               fault_flag;
        color_t             color_class;
        logic [STAT_W-1:0]  time_in_mode;
        logic [STAT_W-1:0]  fault_count;
        logic [STAT_W-1:0]  jobs_completed;
        logic [STAT_W-1:0]  selected_duration;
        logic [STAT_W-1:0]  selected_entries;
        logic [3:0]         queue_level;
    } out_item_t;

    typedef struct packed {
        logic  hit;
        mode_t target;
    } trans_t;

    function automatic logic is_fault(input mode_t m);
        is_fault = (m == MODE_CAL_ERROR) || (m == MODE_HEAT_ERROR) ||
                   (m == MODE_DATA_ERROR) || (m == MODE_LOCK);
    endfunction

    function automatic color_t color_of(input mode_t m);
        case (m)
            MODE_INIT:       color_of = COLOR_ASH;
            MODE_MANUAL:     color_of = COLOR_OTHER;
            MODE_CAL_ERROR,
            MODE_HEAT_ERROR,
            MODE_DATA_ERROR: color_of = COLOR_RED;
            default:         color_of = COLOR_YELLOW;
        endcase
    endfunction

    // Fixed transition table
    function automatic trans_t next_mode(input mode_t m, input logic [4:0] ev);
        trans_t t;
        t.hit    = 1'b1;
        t.target = MODE_INIT;
        case (m)
            MODE_INIT: begin
                if (ev == EV_INIT_DONE) t.target = MODE_IDLE;
                else                    t.hit = 1'b0;
            end
            MODE_IDLE: begin
                if (ev == EV_SELECT_MANUAL)            t.target = MODE_MANUAL;
                else if (ev == EV_TASK_SENT)           t.target = MODE_CALIBRATION;
                else if (ev == EV_REQUEST_CALIBRATION) t.target = MODE_CALIBRATION;
                else                                   t.hit = 1'b0;
            end
            MODE_MANUAL: begin
                if (ev == EV_EXIT_MANUAL) t.target = MODE_IDLE;
                else                      t.hit = 1'b0;
            end
            MODE_CALIBRATION: begin
                if (ev == EV_CALIBRATION_SUCCESS)    t.target = MODE_READY;
                else if (ev == EV_CALIBRATION_ERROR) t.target = MODE_CAL_ERROR;
                else                                 t.hit = 1'b0;
            end
            MODE_READY: begin
                if (ev == EV_CANCEL_TASK)           t.target = MODE_IDLE;
                else if (ev == EV_CALIBRATION_DONE) t.target = MODE_IDLE;
                else if (ev == EV_TASK_APPROVED)    t.target = MODE_HEATING;
                else                                t.hit = 1'b0;
            end
            MODE_HEATING: begin
                if (ev == EV_HEATING_SUCCESS)     t.target = MODE_EXECUTING;
                else if (ev == EV_HEATING_ERROR)  t.target = MODE_HEAT_ERROR;
                else                              t.hit = 1'b0;
            end
            MODE_EXECUTING: begin
                if (ev == EV_PAUSE_REQUEST)      t.target = MODE_PAUSED;
                else if (ev == EV_TASK_DONE)     t.target = MODE_NORMAL_EXIT;
                else if (ev == EV_HEATING_ERROR) t.target = MODE_HEAT_ERROR;
                else if (ev == EV_DATA_ERROR)    t.target = MODE_DATA_ERROR;
                else                             t.hit = 1'b0;
            end
            MODE_PAUSED: begin
                if (ev == EV_EXIT_REQUEST)       t.target = MODE_NORMAL_EXIT;
                else if (ev == EV_CONTINUE_TASK) t.target = MODE_HEATING;
                else                             t.hit = 1'b0;
            end
            MODE_NORMAL_EXIT: begin
                if (ev == EV_COOLDOWN_COMPLETE)  t.target = MODE_IDLE;
                else if (ev == EV_COOLING_ERROR) t.target = MODE_HEAT_ERROR;
                else                             t.hit = 1'b0;
            end
            MODE_CAL_ERROR: begin
                if (ev == EV_CALIBRATION_ERROR) t.target = MODE_LOCK;
                else                            t.hit = 1'b0;
            end
            MODE_HEAT_ERROR: begin
                if (ev == EV_HEATING_ERROR) t.target = MODE_LOCK;
                else                        t.hit = 1'b0;
            end
            MODE_DATA_ERROR: begin
                if (ev == EV_DATA_ERROR) t.target = MODE_LOCK;
                else                     t.hit = 1'b0;
            end
            default: t.hit = 1'b0;
        endcase
        next_mode = t;
    endfunction

endpackage

FILE: rtl/event_driven_mode_controller.sv
// Event-driven mode controller: event queue, transition table and statistics counters.
// A transaction passes through the input register and then the result register before its
// result is presented on the m side.
// Throughput: one transaction per cycle unless m_ready stalls the result; input accepted while a
// result waits, if the input register is free or drains into the result register in the same cycle.
// Reset (aresetn low, synchronous): mode INIT, queue empty, timer, counters and statistics
// zero, both configuration registers zero. Queue storage is not cleared.
module event_driven_mode_controller #(
    parameter int QUEUE_DEPTH = edmc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  edmc_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output edmc_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  edmc_pkg::cfg_reg_t                  cfg_index,
    input  logic [edmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import edmc_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // control and state
    logic                  run_enable_reg;
    logic                  stats_enable_reg;
    logic                  in_valid_reg;
    in_item_t              in_data_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;
    out_item_t             m_data_next;

    mode_t                 mode_reg,  mode_next;
    mode_t                 prior_reg, prior_next;
    logic [IDX_W-1:0]      head_reg,  head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [STAT_W-1:0]     timer_reg, timer_next;
    logic [STAT_W-1:0]     faults_reg, faults_next;
    logic [STAT_W-1:0]     jobs_reg,  jobs_next;
    logic [STAT_W-1:0]     dur_reg   [NUM_MODES];
    logic [STAT_W-1:0]     dur_next  [NUM_MODES];
    logic [STAT_W-1:0]     ent_reg   [NUM_MODES];
    logic [STAT_W-1:0]     ent_next  [NUM_MODES];

    logic [4:0]            queue_mem [QUEUE_DEPTH];
    logic [4:0]            head_data_reg;

    logic                  advance;
    logic                  fire;
    logic                  post_ok;
    logic                  do_trans;
    status_t               status;
    trans_t                trans;
    logic [SUM_W-1:0]      tail_sum;
    logic [IDX_W-1:0]      tail;
    logic [CNT_W+3:0]      level_ext;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
    assign trans    = next_mode(mode_reg, head_data_reg);

    always_comb begin
        status      = ST_OK;
        post_ok     = 1'b0;
        do_trans    = 1'b0;
        mode_next   = mode_reg;
        prior_next  = prior_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        timer_next  = timer_reg;
        faults_next = faults_reg;
        jobs_next   = jobs_reg;
        for (int i = 0; i < NUM_MODES; i++) begin
            dur_next[i] = dur_reg[i];
            ent_next[i] = ent_reg[i];
        end
        if (fire) begin
            case (in_data_reg.cmd)
                CMD_POST: begin
                    if (in_data_reg.event_code >= NUM_EVENTS) begin
                        status = ST_BAD_EVENT;
                    end else if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                        status = ST_QUEUE_FULL;
                    end else begin
                        post_ok    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_PROCESS: begin
                    if (!run_enable_reg || count_reg == '0) begin
                        status = ST_NOTHING;
                    end else begin
                        head_next  = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ?
                                     '0 : head_reg + IDX_W'(1);
                        count_next = count_reg - CNT_W'(1);
                        if (trans.hit) begin
                            do_trans = 1'b1;
                        end else begin
                            status = ST_NO_TRANSITION;
                        end
                    end
                end
                CMD_TICK: begin
                    timer_next = timer_reg + STAT_W'(1);
                end
                CMD_CLEAR: begin
                    for (int i = 0; i < NUM_MODES; i++) begin
                        dur_next[i] = '0;
                        ent_next[i] = '0;
                    end
                    faults_next = '0;
                    jobs_next   = '0;
                end
                default: begin
                    status = ST_OK;
                end
            endcase
        end
        if (do_trans) begin
            if (stats_enable_reg) begin
                dur_next[mode_reg]     = dur_reg[mode_reg] + timer_reg;
                ent_next[trans.target] = ent_reg[trans.target] + STAT_W'(1);
                if (is_fault(trans.target)) begin
                    faults_next = faults_reg + STAT_W'(1);
                end
                if (trans.target == MODE_IDLE && mode_reg == MODE_NORMAL_EXIT) begin
                    jobs_next = jobs_reg + STAT_W'(1);
                end
            end
            prior_next = mode_reg;
            mode_next  = trans.target;
            timer_next = '0;
        end
    end

    assign level_ext = {4'b0000, count_next};

    always_comb begin
        m_data_next.mode_now       = mode_next;
        m_data_next.mode_before    = prior_next;
        m_data_next.status         = status;
        m_data_next.fault_flag     = is_fault(mode_next);
        m_data_next.color_class    = color_of(mode_next);
        m_data_next.time_in_mode   = timer_next;
        m_data_next.fault_count    = faults_next;
        m_data_next.jobs_completed = jobs_next;
        m_data_next.queue_level    = level_ext[3:0];
        if (in_data_reg.stat_select < 4'(NUM_MODES)) begin
            m_data_next.selected_duration = dur_next[in_data_reg.stat_select];
            m_data_next.selected_entries  = ent_next[in_data_reg.stat_select];
        end else begin
            m_data_next.selected_duration = '0;
            m_data_next.selected_entries  = '0;
        end
    end

    // handshake and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            run_enable_reg   <= 1'b0;
            stats_enable_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RUN_ENABLE:   run_enable_reg   <= cfg_data[0];
                    CFG_STATS_ENABLE: stats_enable_reg <= cfg_data[0];
                    default:          run_enable_reg   <= run_enable_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    // controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_INIT;
            prior_reg  <= MODE_INIT;
            head_reg   <= '0;
            count_reg  <= '0;
            timer_reg  <= '0;
            faults_reg <= '0;
            jobs_reg   <= '0;
            for (int i = 0; i < NUM_MODES; i++) begin
                dur_reg[i] <= '0;
                ent_reg[i] <= '0;
            end
        end else begin
            mode_reg   <= mode_next;
            prior_reg  <= prior_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            timer_reg  <= timer_next;
            faults_reg <= faults_next;
            jobs_reg   <= jobs_next;
            for (int i = 0; i < NUM_MODES; i++) begin
                dur_reg[i] <= dur_next[i];
                ent_reg[i] <= ent_next[i];
            end
        end
    end

    // event queue; the head entry is prefetched, with bypass of a post into an empty queue
    always_ff @(posedge aclk) begin
        if (post_ok) begin
            queue_mem[tail] <= in_data_reg.event_code;
        end
        if (post_ok && tail == head_next) begin
            head_data_reg <= in_data_reg.event_code;
        end else begin
            head_data_reg <= queue_mem[head_next];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        do_trans |=> (timer_reg == '0) && (prior_reg == $past(mode_reg)))
        else $error("transition did not restart timer or record prior mode");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.fault_flag == is_fault(m_data_reg.mode_now)))
        else $error("fault flag disagrees with reported mode");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_data_reg.cmd == CMD_POST && status == ST_OK) |=>
        (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("accepted post not counted");

endmodule
